FILE: hdl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the projection core.
// Depends on nothing; users must provide clk and rst signals in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/lpcp_pkg.sv
// Package for the lidar point camera projection core: item types and constants.
// Depends on nothing.
package lpcp_pkg;

  localparam int PIXEL_BITS = 12;
  localparam int FRAC_BITS_DEFAULT = 16;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_INDEX_W = 3;
  localparam int DIM_W = 13;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ROW0_AB = 3'd0,
    REG_ROW0_CD = 3'd1,
    REG_ROW1_AB = 3'd2,
    REG_ROW1_CD = 3'd3,
    REG_ROW2_AB = 3'd4,
    REG_ROW2_CD = 3'd5,
    REG_IMAGE_WIDTH = 3'd6,
    REG_IMAGE_HEIGHT = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
  } point_t;

  typedef struct packed {
    logic                  in_image;
    logic [PIXEL_BITS-1:0] pixel_col;
    logic [PIXEL_BITS-1:0] pixel_row;
    logic signed [31:0]    depth_value;
    logic signed [31:0]    echo_x;
    logic signed [31:0]    echo_y;
    logic signed [31:0]    echo_z;
  } result_t;

endpackage

FILE: hdl/lidar_point_camera_projection_core.sv
// Throughput: one point per cycle; the whole pipeline advances unless the result is stalled.
// The pixel divisions are restoring dividers, one quotient bit per stage, PIXEL_BITS stages.
// Reset clears all valid bits and loads the matrix with zeros, width 3270 and height 2048.
// Top level of the lidar point camera projection core.
// Depends on lpcp_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lidar_point_camera_projection_core #(
  parameter int FRAC_BITS = lpcp_pkg::FRAC_BITS_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [lpcp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lpcp_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               point_valid,
  output logic                               point_stall,
  input  lpcp_pkg::point_t                   point,
  output logic                               result_valid,
  input  logic                               result_stall,
  output lpcp_pkg::result_t                  result
);
  import lpcp_pkg::*;

  localparam int P = PIXEL_BITS;
  localparam int SUM_W = 66 - FRAC_BITS;
  localparam int NW = SUM_W + 2;
  localparam int DIV_W = NW + P;
  localparam int LIM_W = 17;
  localparam logic [LIM_W-1:0] LIM = LIM_W'(1) << P;
  localparam logic signed [SUM_W-1:0] DEPTH_MAX = SUM_W'(64'sd2147483647);
  localparam logic signed [SUM_W-1:0] DEPTH_MIN = SUM_W'(-64'sd2147483648);

  typedef struct packed {
    logic [NW-1:0]      rem0;
    logic [NW-1:0]      rem1;
    logic [P-1:0]       q0;
    logic [P-1:0]       q1;
    logic [NW-1:0]      d;
    logic               neg0;
    logic               neg1;
    logic               zero;
    logic               ovf0;
    logic               ovf1;
    logic signed [31:0] depth;
    point_t             pt;
  } div_t;

  logic [CFG_DATA_W-1:0] mat [0:5];
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;
  logic [P:0] w_lim;
  logic [P:0] h_lim;

  logic advance;

  logic signed [31:0] coef [0:2][0:3];
  logic signed [63:0] prod [0:2][0:2];
  logic signed [31:0] c3 [0:2];
  point_t pt1;
  logic v1;

  logic signed [SUM_W-1:0] sum [0:2];
  point_t pt2;
  logic v2;

  logic [SUM_W-1:0] abs0;
  logic [SUM_W-1:0] abs1;
  logic [SUM_W-1:0] abs2;
  div_t s3;
  logic v3;

  div_t dv_in;
  div_t dv [0:P];
  div_t dn [1:P];
  logic dv_valid [0:P];
  logic [DIV_W-1:0] dsh [1:P];

  logic in0;
  logic in1;
  logic on_image;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        mat[i] <= '0;
      end
      image_width <= DIM_W'(3270);
      image_height <= DIM_W'(2048);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ROW0_AB: mat[0] <= cfg_data;
        REG_ROW0_CD: mat[1] <= cfg_data;
        REG_ROW1_AB: mat[2] <= cfg_data;
        REG_ROW1_CD: mat[3] <= cfg_data;
        REG_ROW2_AB: mat[4] <= cfg_data;
        REG_ROW2_CD: mat[5] <= cfg_data;
        REG_IMAGE_WIDTH: image_width <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[DIM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      coef[r][0] = mat[2*r][63:32];
      coef[r][1] = mat[2*r][31:0];
      coef[r][2] = mat[2*r+1][63:32];
      coef[r][3] = mat[2*r+1][31:0];
    end
    w_lim = (LIM_W'(image_width) > LIM) ? LIM[P:0] : (P+1)'(image_width);
    h_lim = (LIM_W'(image_height) > LIM) ? LIM[P:0] : (P+1)'(image_height);
  end

  assign advance = !(result_valid && result_stall);
  assign point_stall = !advance;

  // Stage 1: nine 32x32 products.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (advance) begin
      v1 <= point_valid;
    end
    if (advance) begin
      for (int r = 0; r < 3; r++) begin
        prod[r][0] <= 64'(coef[r][0]) * 64'(point.point_x);
        prod[r][1] <= 64'(coef[r][1]) * 64'(point.point_y);
        prod[r][2] <= 64'(coef[r][2]) * 64'(point.point_z);
        c3[r] <= coef[r][3];
      end
      pt1 <= point;
    end
  end

  // Stage 2: floor-shifted row sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (advance) begin
      v2 <= v1;
    end
    if (advance) begin
      for (int r = 0; r < 3; r++) begin
        sum[r] <= SUM_W'(prod[r][0] >>> FRAC_BITS) + SUM_W'(prod[r][1] >>> FRAC_BITS)
                + SUM_W'(prod[r][2] >>> FRAC_BITS) + SUM_W'(c3[r]);
      end
      pt2 <= pt1;
    end
  end

  // Stage 3: magnitudes, rounding numerators and saturated depth.
  always_comb begin
    abs0 = sum[0][SUM_W-1] ? SUM_W'(-sum[0]) : SUM_W'(sum[0]);
    abs1 = sum[1][SUM_W-1] ? SUM_W'(-sum[1]) : SUM_W'(sum[1]);
    abs2 = sum[2][SUM_W-1] ? SUM_W'(-sum[2]) : SUM_W'(sum[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (advance) begin
      v3 <= v2;
    end
    if (advance) begin
      s3.rem0 <= (NW'(abs0) << 1) + NW'(abs2);
      s3.rem1 <= (NW'(abs1) << 1) + NW'(abs2);
      s3.d <= NW'(abs2) << 1;
      s3.q0 <= '0;
      s3.q1 <= '0;
      s3.neg0 <= sum[0][SUM_W-1] ^ sum[2][SUM_W-1];
      s3.neg1 <= sum[1][SUM_W-1] ^ sum[2][SUM_W-1];
      s3.zero <= (sum[2] == '0);
      s3.ovf0 <= 1'b0;
      s3.ovf1 <= 1'b0;
      if (sum[2] > DEPTH_MAX) begin
        s3.depth <= 32'sh7fffffff;
      end else if (sum[2] < DEPTH_MIN) begin
        s3.depth <= 32'sh80000000;
      end else begin
        s3.depth <= 32'(sum[2]);
      end
      s3.pt <= pt2;
    end
  end

  // Stage 4: quotient range check, then one quotient bit per stage.
  always_comb begin
    dv_in = s3;
    dv_in.ovf0 = DIV_W'(s3.rem0) >= (DIV_W'(s3.d) << P);
    dv_in.ovf1 = DIV_W'(s3.rem1) >= (DIV_W'(s3.d) << P);
  end

  always_comb begin
    for (int j = 1; j <= P; j++) begin
      dn[j] = dv[j-1];
      dsh[j] = DIV_W'(dv[j-1].d) << (P - j);
      if (DIV_W'(dv[j-1].rem0) >= dsh[j]) begin
        dn[j].rem0 = dv[j-1].rem0 - NW'(dsh[j]);
        dn[j].q0[P-j] = 1'b1;
      end
      if (DIV_W'(dv[j-1].rem1) >= dsh[j]) begin
        dn[j].rem1 = dv[j-1].rem1 - NW'(dsh[j]);
        dn[j].q1[P-j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j <= P; j++) begin
        dv_valid[j] <= 1'b0;
      end
    end else if (advance) begin
      dv_valid[0] <= v3;
      for (int j = 1; j <= P; j++) begin
        dv_valid[j] <= dv_valid[j-1];
      end
    end
    if (advance) begin
      dv[0] <= dv_in;
      for (int j = 1; j <= P; j++) begin
        dv[j] <= dn[j];
      end
    end
  end

  // Output register.
  always_comb begin
    in0 = !dv[P].ovf0 && (!dv[P].neg0 || dv[P].q0 == '0) && ({1'b0, dv[P].q0} < w_lim);
    in1 = !dv[P].ovf1 && (!dv[P].neg1 || dv[P].q1 == '0) && ({1'b0, dv[P].q1} < h_lim);
    on_image = !dv[P].zero && in0 && in1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= dv_valid[P];
    end
    if (advance) begin
      result.in_image <= on_image;
      result.pixel_col <= on_image ? dv[P].q0 : '0;
      result.pixel_row <= on_image ? dv[P].q1 : '0;
      result.depth_value <= dv[P].depth;
      result.echo_x <= dv[P].pt.point_x;
      result.echo_y <= dv[P].pt.point_y;
      result.echo_z <= dv[P].pt.point_z;
    end
  end

  `ASSERT_IMPL(a_outside_zero, result_valid && !result.in_image,
               result.pixel_col == '0 && result.pixel_row == '0)
  `ASSERT_IMPL(a_inside_depth, result_valid && result.in_image, result.depth_value != '0)
  `ASSERT_IMPL(a_inside_bounds, result_valid && result.in_image,
               {1'b0, result.pixel_col} < w_lim && {1'b0, result.pixel_row} < h_lim)

endmodule
